### src/cslx_pkg.sv
// ----------------------------------------------------------------------------
// cslx_pkg: shared types and constants of the character stream lexer
// Character codes, class codes, token tags, queue sizes and the digit weight
// table for the fraction of a number.
// ----------------------------------------------------------------------------
package cslx_pkg;

   // default widths
   localparam int VALUE_BITS_DEF = 32;
   localparam int LINE_BITS_DEF  = 24;
   localparam int FRAC_BITS_DEF  = 16;

   // fixed widths
   localparam int CHAR_W   = 8;
   localparam int TAG_W    = 9;
   localparam int LEN_W    = 16;
   localparam int WEIGHT_W = 32;
   localparam int WIDX_W   = 4;
   localparam int CLS_W    = 4;
   localparam int MODE_W   = 4;

   // queue depths
   localparam int QDEPTH   = 4;
   localparam int RQ_DEPTH = 4;

   // characters
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CH_BANG  = 8'd33;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'd42;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'd46;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'd47;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] CH_LT    = 8'd60;
   localparam logic [CHAR_W-1:0] CH_EQ    = 8'd61;
   localparam logic [CHAR_W-1:0] CH_GT    = 8'd62;
   localparam logic [CHAR_W-1:0] CH_UC_A  = 8'd65;
   localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'd90;
   localparam logic [CHAR_W-1:0] CH_LC_A  = 8'd97;
   localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'd122;

   // character classes
   localparam logic [CLS_W-1:0] CLS_OTHER   = 4'd0;
   localparam logic [CLS_W-1:0] CLS_BLANK   = 4'd1;
   localparam logic [CLS_W-1:0] CLS_NEWLINE = 4'd2;
   localparam logic [CLS_W-1:0] CLS_SLASH   = 4'd3;
   localparam logic [CLS_W-1:0] CLS_STAR    = 4'd4;
   localparam logic [CLS_W-1:0] CLS_DIGIT   = 4'd5;
   localparam logic [CLS_W-1:0] CLS_DOT     = 4'd6;
   localparam logic [CLS_W-1:0] CLS_LETTER  = 4'd7;
   localparam logic [CLS_W-1:0] CLS_LT      = 4'd8;
   localparam logic [CLS_W-1:0] CLS_GT      = 4'd9;
   localparam logic [CLS_W-1:0] CLS_EQ      = 4'd10;
   localparam logic [CLS_W-1:0] CLS_BANG    = 4'd11;

   // token tags
   localparam logic [TAG_W-1:0] TAG_NUM = 9'd256;
   localparam logic [TAG_W-1:0] TAG_ID  = 9'd257;
   localparam logic [TAG_W-1:0] TAG_LT  = 9'd260;
   localparam logic [TAG_W-1:0] TAG_LE  = 9'd261;
   localparam logic [TAG_W-1:0] TAG_EQ  = 9'd262;
   localparam logic [TAG_W-1:0] TAG_NE  = 9'd263;
   localparam logic [TAG_W-1:0] TAG_GE  = 9'd264;
   localparam logic [TAG_W-1:0] TAG_GT  = 9'd265;
   localparam logic [TAG_W-1:0] TAG_END = 9'd266;

   // weight index stops here, the weight is zero from then on
   localparam logic [WIDX_W-1:0] WIDX_LAST = 4'd9;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              is_end;
      logic [CLS_W-1:0]  cls;
   } item_type;

   typedef struct packed {
      logic first;
      logic second;
   } rq_wr_type;

   // weight of the n-th fraction digit in Q0.32, w(n+1) = (w(n)+5)/10
   function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [WIDX_W-1:0] idx);
      logic [WEIGHT_W-1:0] w;
      unique case (idx)
         4'd0:    w = 32'h1999999A;
         4'd1:    w = 32'd42949673;
         4'd2:    w = 32'd4294967;
         4'd3:    w = 32'd429497;
         4'd4:    w = 32'd42950;
         4'd5:    w = 32'd4295;
         4'd6:    w = 32'd430;
         4'd7:    w = 32'd43;
         4'd8:    w = 32'd4;
         default: w = 32'd0;
      endcase
      return w;
   endfunction

endpackage

### src/cslx_front.sv
// ----------------------------------------------------------------------------
// cslx_front: input side of the lexer
// Takes character words, sorts each into a character class and holds them in
// a short queue for the lexer core.
// ----------------------------------------------------------------------------
module cslx_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [cslx_pkg::CHAR_W-1:0]     in_ch,
   input  logic                            in_is_end,
   output logic                            item_valid,
   output cslx_pkg::item_type              item,
   input  logic                            item_pop
);

   localparam int PTR_W = $clog2(cslx_pkg::QDEPTH);
   localparam int CNT_W = $clog2(cslx_pkg::QDEPTH + 1);

   cslx_pkg::item_type queue_ff [cslx_pkg::QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   cslx_pkg::item_type new_item;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(cslx_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [cslx_pkg::CLS_W-1:0] classify(
      input logic [cslx_pkg::CHAR_W-1:0] c);
      logic [cslx_pkg::CLS_W-1:0] k;
      k = cslx_pkg::CLS_OTHER;
      if (c == cslx_pkg::CH_SPACE || c == cslx_pkg::CH_TAB) begin
         k = cslx_pkg::CLS_BLANK;
      end else if (c == cslx_pkg::CH_NL) begin
         k = cslx_pkg::CLS_NEWLINE;
      end else if (c == cslx_pkg::CH_SLASH) begin
         k = cslx_pkg::CLS_SLASH;
      end else if (c == cslx_pkg::CH_STAR) begin
         k = cslx_pkg::CLS_STAR;
      end else if (c >= cslx_pkg::CH_ZERO && c <= cslx_pkg::CH_NINE) begin
         k = cslx_pkg::CLS_DIGIT;
      end else if (c == cslx_pkg::CH_DOT) begin
         k = cslx_pkg::CLS_DOT;
      end else if ((c >= cslx_pkg::CH_UC_A && c <= cslx_pkg::CH_UC_Z) ||
                   (c >= cslx_pkg::CH_LC_A && c <= cslx_pkg::CH_LC_Z)) begin
         k = cslx_pkg::CLS_LETTER;
      end else if (c == cslx_pkg::CH_LT) begin
         k = cslx_pkg::CLS_LT;
      end else if (c == cslx_pkg::CH_GT) begin
         k = cslx_pkg::CLS_GT;
      end else if (c == cslx_pkg::CH_EQ) begin
         k = cslx_pkg::CLS_EQ;
      end else if (c == cslx_pkg::CH_BANG) begin
         k = cslx_pkg::CLS_BANG;
      end
      return k;
   endfunction

   assign in_ready   = (count_ff != CNT_W'(cslx_pkg::QDEPTH));
   assign push       = in_valid && in_ready;
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      new_item.ch     = in_ch;
      new_item.is_end = in_is_end;
      new_item.cls    = classify(in_ch);
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = item_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

### src/cslx_back.sv
// ----------------------------------------------------------------------------
// cslx_back: lexer core
// Runs the token state machine on one classified character per cycle while the result
// queue has room for two tokens, and writes up to two finished tokens into that queue.
// ----------------------------------------------------------------------------
module cslx_back #(
   parameter int  VALUE_BITS = cslx_pkg::VALUE_BITS_DEF,
   parameter int  LINE_BITS  = cslx_pkg::LINE_BITS_DEF,
   parameter int  FRAC_BITS  = cslx_pkg::FRAC_BITS_DEF,
   localparam int DATA_W     =
      ((LINE_BITS + VALUE_BITS + FRAC_BITS + cslx_pkg::LEN_W + 7) / 8) * 8,
   localparam int ENT_W      = cslx_pkg::TAG_W + DATA_W + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  cslx_pkg::item_type item,
   output logic               item_pop,
   input  logic               room,
   output cslx_pkg::rq_wr_type wr,
   output logic [ENT_W-1:0]   ent0,
   output logic [ENT_W-1:0]   ent1
);

   localparam logic [cslx_pkg::MODE_W-1:0] M_IDLE       = 4'd0;
   localparam logic [cslx_pkg::MODE_W-1:0] M_SLASH      = 4'd1;
   localparam logic [cslx_pkg::MODE_W-1:0] M_LINE_CMT   = 4'd2;
   localparam logic [cslx_pkg::MODE_W-1:0] M_BLOCK_CMT  = 4'd3;
   localparam logic [cslx_pkg::MODE_W-1:0] M_BLOCK_STAR = 4'd4;
   localparam logic [cslx_pkg::MODE_W-1:0] M_INT        = 4'd5;
   localparam logic [cslx_pkg::MODE_W-1:0] M_FRAC       = 4'd6;
   localparam logic [cslx_pkg::MODE_W-1:0] M_IDENT      = 4'd7;
   localparam logic [cslx_pkg::MODE_W-1:0] M_REL        = 4'd8;

   localparam int IW       = VALUE_BITS + 4;
   localparam int PW       = cslx_pkg::WEIGHT_W + 4;
   localparam int SW       = PW + 1;
   localparam int FRAC_SH  = cslx_pkg::WEIGHT_W - FRAC_BITS;
   localparam logic [PW-1:0] RND = (PW'(1) << FRAC_SH) >> 1;
   localparam logic [VALUE_BITS-1:0]     VMAX = '1;
   localparam logic [FRAC_BITS-1:0]      FMAX = '1;
   localparam logic [LINE_BITS-1:0]      LMAX = '1;
   localparam logic [cslx_pkg::LEN_W-1:0] IDMAX = '1;

   logic [cslx_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [cslx_pkg::CHAR_W-1:0] held_ff, held_in;
   logic [LINE_BITS-1:0]        line_ff, line_in;
   logic [VALUE_BITS-1:0]       int_ff, int_in;
   logic [FRAC_BITS-1:0]        frac_ff, frac_in;
   logic [cslx_pkg::WIDX_W-1:0] widx_ff, widx_in;
   logic [cslx_pkg::LEN_W-1:0]  idcnt_ff, idcnt_in;

   logic                        fire;
   logic                        do_flush, do_start, rel_hit, end_hit, line_inc, start_push;
   logic [3:0]                  digit;
   logic [IW-1:0]               int_sum;
   logic [PW-1:0]               prod, prnd;
   logic [SW-1:0]               frac_sum;

   logic                        f_has;
   logic [cslx_pkg::TAG_W-1:0]  f_tag, rel_tag, a_tag, b_tag;
   logic [VALUE_BITS-1:0]       f_int;
   logic [FRAC_BITS-1:0]        f_frac;
   logic [cslx_pkg::LEN_W-1:0]  f_len;
   logic                        a_valid, b_valid;
   logic [ENT_W-1:0]            a_ent, b_ent;

   assign fire     = item_valid && room;
   assign item_pop = fire;
   assign digit    = item.ch[3:0];

   // digit arithmetic
   always_comb begin
      int_sum  = (IW'(int_ff) << 3) + (IW'(int_ff) << 1) + IW'(digit);
      prod     = PW'(digit) * PW'(cslx_pkg::frac_weight(widx_ff));
      prnd     = (prod + RND) >> FRAC_SH;
      frac_sum = SW'(frac_ff) + SW'(prnd);
   end

   // token pending in the current mode
   always_comb begin
      f_has  = 1'b1;
      f_tag  = '0;
      f_int  = '0;
      f_frac = '0;
      f_len  = '0;
      unique case (mode_ff)
         M_SLASH: begin
            f_tag = cslx_pkg::TAG_W'(cslx_pkg::CH_SLASH);
         end
         M_INT, M_FRAC: begin
            f_tag  = cslx_pkg::TAG_NUM;
            f_int  = int_ff;
            f_frac = frac_ff;
         end
         M_IDENT: begin
            f_tag = cslx_pkg::TAG_ID;
            f_len = idcnt_ff;
         end
         M_REL: begin
            if (held_ff == cslx_pkg::CH_LT) begin
               f_tag = cslx_pkg::TAG_LT;
            end else if (held_ff == cslx_pkg::CH_GT) begin
               f_tag = cslx_pkg::TAG_GT;
            end else begin
               f_tag = cslx_pkg::TAG_W'(held_ff);
            end
         end
         default: begin
            f_has = 1'b0;
         end
      endcase
      priority if (held_ff == cslx_pkg::CH_LT) begin
         rel_tag = cslx_pkg::TAG_LE;
      end else if (held_ff == cslx_pkg::CH_GT) begin
         rel_tag = cslx_pkg::TAG_GE;
      end else if (held_ff == cslx_pkg::CH_EQ) begin
         rel_tag = cslx_pkg::TAG_EQ;
      end else begin
         rel_tag = cslx_pkg::TAG_NE;
      end
   end

   // next state
   always_comb begin
      mode_in    = mode_ff;
      held_in    = held_ff;
      line_in    = line_ff;
      int_in     = int_ff;
      frac_in    = frac_ff;
      widx_in    = widx_ff;
      idcnt_in   = idcnt_ff;
      do_flush   = 1'b0;
      do_start   = 1'b0;
      rel_hit    = 1'b0;
      end_hit    = 1'b0;
      line_inc   = 1'b0;
      start_push = 1'b0;

      if (item.is_end) begin
         do_flush = 1'b1;
         end_hit  = 1'b1;
      end else begin
         unique case (mode_ff)
            M_SLASH: begin
               if (item.cls == cslx_pkg::CLS_SLASH) begin
                  mode_in = M_LINE_CMT;
               end else if (item.cls == cslx_pkg::CLS_STAR) begin
                  mode_in = M_BLOCK_CMT;
               end else begin
                  do_flush = 1'b1;
                  do_start = 1'b1;
               end
            end
            M_LINE_CMT: begin
               if (item.cls == cslx_pkg::CLS_NEWLINE) begin
                  line_inc = 1'b1;
                  mode_in  = M_IDLE;
               end
            end
            M_BLOCK_CMT: begin
               if (item.cls == cslx_pkg::CLS_STAR) begin
                  mode_in = M_BLOCK_STAR;
               end else if (item.cls == cslx_pkg::CLS_NEWLINE) begin
                  line_inc = 1'b1;
               end
            end
            M_BLOCK_STAR: begin
               // a run of stars stays here; a slash closes the comment, any other character goes back to the body
               if (item.cls == cslx_pkg::CLS_SLASH) begin
                  mode_in = M_IDLE;
               end else if (item.cls != cslx_pkg::CLS_STAR) begin
                  line_inc = (item.cls == cslx_pkg::CLS_NEWLINE);
                  mode_in  = M_BLOCK_CMT;
               end
            end
            M_INT: begin
               if (item.cls == cslx_pkg::CLS_DIGIT) begin
                  int_in = (int_sum > IW'(VMAX)) ? VMAX : int_sum[VALUE_BITS-1:0];
               end else if (item.cls == cslx_pkg::CLS_DOT) begin
                  mode_in = M_FRAC;
               end else begin
                  do_flush = 1'b1;
                  do_start = 1'b1;
               end
            end
            M_FRAC: begin
               if (item.cls == cslx_pkg::CLS_DIGIT) begin
                  frac_in = (frac_sum > SW'(FMAX)) ? FMAX : frac_sum[FRAC_BITS-1:0];
                  widx_in = (widx_ff == cslx_pkg::WIDX_LAST) ? widx_ff : widx_ff + 1'b1;
               end else begin
                  do_flush = 1'b1;
                  do_start = 1'b1;
               end
            end
            M_IDENT: begin
               if (item.cls == cslx_pkg::CLS_LETTER) begin
                  if (idcnt_ff != IDMAX) begin
                     idcnt_in = idcnt_ff + 1'b1;
                  end
               end else begin
                  do_flush = 1'b1;
                  do_start = 1'b1;
               end
            end
            M_REL: begin
               if (item.cls == cslx_pkg::CLS_EQ) begin
                  rel_hit = 1'b1;
               end else begin
                  do_flush = 1'b1;
                  do_start = 1'b1;
               end
            end
            default: begin
               do_start = 1'b1;
            end
         endcase
      end

      // token done: back to idle with cleared token fields
      if (do_flush || rel_hit || do_start) begin
         mode_in  = M_IDLE;
         held_in  = '0;
         int_in   = '0;
         frac_in  = '0;
         widx_in  = '0;
         idcnt_in = '0;
      end

      if (do_start) begin
         unique case (item.cls)
            cslx_pkg::CLS_BLANK: begin
            end
            cslx_pkg::CLS_NEWLINE: begin
               line_inc = 1'b1;
            end
            cslx_pkg::CLS_SLASH: begin
               mode_in = M_SLASH;
            end
            cslx_pkg::CLS_DIGIT: begin
               int_in  = VALUE_BITS'(digit);
               mode_in = M_INT;
            end
            cslx_pkg::CLS_DOT: begin
               mode_in = M_FRAC;
            end
            cslx_pkg::CLS_LETTER: begin
               idcnt_in = cslx_pkg::LEN_W'(1);
               mode_in  = M_IDENT;
            end
            cslx_pkg::CLS_LT, cslx_pkg::CLS_GT, cslx_pkg::CLS_EQ, cslx_pkg::CLS_BANG: begin
               held_in = item.ch;
               mode_in = M_REL;
            end
            default: begin
               start_push = 1'b1;
            end
         endcase
      end

      if (line_inc && line_ff != LMAX) begin
         line_in = line_ff + 1'b1;
      end

      if (end_hit) begin
         line_in = LINE_BITS'(1);
      end
   end

   // result assembly: a is the token that ends here, b the one started or the end tag
   always_comb begin
      a_valid = (do_flush && f_has) || rel_hit;
      b_valid = start_push || end_hit;
      a_tag   = rel_hit ? rel_tag : f_tag;
      b_tag   = end_hit ? cslx_pkg::TAG_END : cslx_pkg::TAG_W'(item.ch);
      a_ent   = {a_tag, DATA_W'({f_len, f_frac, f_int, line_ff}), !b_valid};
      b_ent   = {b_tag, DATA_W'(line_ff), 1'b1};
      ent0    = a_valid ? a_ent : b_ent;
      ent1    = b_ent;
      wr.first  = fire && (a_valid || b_valid);
      wr.second = fire && a_valid && b_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         held_ff  <= '0;
         line_ff  <= LINE_BITS'(1);
         int_ff   <= '0;
         frac_ff  <= '0;
         widx_ff  <= '0;
         idcnt_ff <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         held_ff  <= held_in;
         line_ff  <= line_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         widx_ff  <= widx_in;
         idcnt_ff <= idcnt_in;
      end
   end

endmodule

### src/cslx_rspq.sv
// ----------------------------------------------------------------------------
// cslx_rspq: result queue
// Takes up to two tokens a cycle from the lexer core and hands out one word
// a cycle on the result port while the receiver is ready.
// ----------------------------------------------------------------------------
module cslx_rspq #(
   parameter int W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  cslx_pkg::rq_wr_type wr,
   input  logic [W-1:0]        din0,
   input  logic [W-1:0]        din1,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [W-1:0]        dout
);

   localparam int PTR_W = $clog2(cslx_pkg::RQ_DEPTH);
   localparam int CNT_W = $clog2(cslx_pkg::RQ_DEPTH + 1);

   logic [W-1:0]     queue_ff [cslx_pkg::RQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(cslx_pkg::RQ_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // room for a pair of tokens
   assign room      = (count_ff <= CNT_W'(cslx_pkg::RQ_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign dout      = queue_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_nx = ptr_next(wr_ptr_ff);
      wr_ptr_in = wr_ptr_ff;
      if (wr.second) begin
         wr_ptr_in = ptr_next(wr_ptr_nx);
      end else if (wr.first) begin
         wr_ptr_in = wr_ptr_nx;
      end
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(wr.first) + CNT_W'(wr.second) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.first) begin
         queue_ff[wr_ptr_ff] <= din0;
      end
      if (wr.second) begin
         queue_ff[wr_ptr_nx] <= din1;
      end
   end

endmodule

### src/char_stream_lexer_unit.sv
// ----------------------------------------------------------------------------
// char_stream_lexer_unit: character stream tokenizer
// Turns a byte stream into tokens: numbers, identifiers, relational
// operators and single characters, skipping blanks and comments.
//
//   channel  dir  words          fields
//   req_     in   one char       tdata: ch; tuser: is_end
//   rsp_     out  one token      tdata: line_no, int_value, frac_value,
//                                ident_len; tuser: tag; tlast: last
//
// One character a cycle goes through the input queue into the lexer core while the
// result queue has room; the core writes up to two tokens into that four-entry queue.
// A token reaches rsp_ only after its character has passed the input queue and the result queue.
// Sustained rate is one word a cycle on each side when neither side stalls; the rsp_
// port moves one token a cycle, so characters that close one token and make another
// put two words on that port, absorbed by the result queue.
// Reset is synchronous and clears both queues and the lexer state.
// Either side may stall at any time; the core waits while the result queue
// has no room for two tokens.
// ----------------------------------------------------------------------------
module char_stream_lexer_unit #(
   parameter int  VALUE_BITS = cslx_pkg::VALUE_BITS_DEF,
   parameter int  LINE_BITS  = cslx_pkg::LINE_BITS_DEF,
   parameter int  FRAC_BITS  = cslx_pkg::FRAC_BITS_DEF,
   localparam int DATA_W     =
      ((LINE_BITS + VALUE_BITS + FRAC_BITS + cslx_pkg::LEN_W + 7) / 8) * 8,
   localparam int ENT_W      = cslx_pkg::TAG_W + DATA_W + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [cslx_pkg::CHAR_W-1:0]  req_tdata,  // ch
   input  logic                         req_tuser,  // is_end
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [DATA_W-1:0]            rsp_tdata,  // line_no, int_value, frac_value, ident_len
   output logic [cslx_pkg::TAG_W-1:0]   rsp_tuser,  // tag
   output logic                         rsp_tlast
);

   logic                item_valid;
   cslx_pkg::item_type  item;
   logic                item_pop;
   logic                room;
   cslx_pkg::rq_wr_type wr;
   logic [ENT_W-1:0]    ent0;
   logic [ENT_W-1:0]    ent1;
   logic [ENT_W-1:0]    head;

   cslx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_ch      (req_tdata),
      .in_is_end  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   cslx_back #(
      .VALUE_BITS (VALUE_BITS),
      .LINE_BITS  (LINE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .room       (room),
      .wr         (wr),
      .ent0       (ent0),
      .ent1       (ent1)
   );

   cslx_rspq #(
      .W (ENT_W)
   ) u_rspq (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .din0      (ent0),
      .din1      (ent1),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .dout      (head)
   );

   assign rsp_tuser = head[ENT_W-1 -: cslx_pkg::TAG_W];
   assign rsp_tdata = head[DATA_W:1];
   assign rsp_tlast = head[0];

endmodule

### src/cslx_checker.sv
// ----------------------------------------------------------------------------
// cslx_checker: port checks for the lexer
// Watches the top level ports for queue reset, stalled words, tag codes and the end tag's last flag.
// ----------------------------------------------------------------------------
module cslx_checker #(
   parameter int DATA_W = 8
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [DATA_W-1:0]          rsp_tdata,
   input logic [cslx_pkg::TAG_W-1:0] rsp_tuser,
   input logic                       rsp_tlast
);

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_tvalid && req_tready))
      else $error("queues not empty after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled token changed");

   // no tag codes outside the token set
   a_tag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= cslx_pkg::TAG_END &&
                      !(rsp_tuser > cslx_pkg::TAG_ID && rsp_tuser < cslx_pkg::TAG_LT)))
      else $error("token tag out of range");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == cslx_pkg::TAG_END) |-> rsp_tlast)
      else $error("end tag without last");

endmodule

bind char_stream_lexer_unit cslx_checker #(
   .DATA_W (DATA_W)
) u_cslx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### sim/char_stream_lexer_unit_tb.sv
// ----------------------------------------------------------------------------
// char_stream_lexer_unit_tb: self-checking bench for the stream lexer
// Feeds characters and end marks to the req_ channel and checks every token
// on rsp_ against a scanner model kept in the bench or a typed row's token.
// A short table of directed characters comes first, then phases of random
// token text under changing idle and stall patterns.
// ----------------------------------------------------------------------------
module char_stream_lexer_unit_tb;

   localparam int CHAR_W      = cslx_pkg::CHAR_W;
   localparam int TAG_W       = cslx_pkg::TAG_W;
   localparam int LEN_W       = cslx_pkg::LEN_W;
   localparam int WEIGHT_W    = cslx_pkg::WEIGHT_W;
   localparam int LINE_W      = cslx_pkg::LINE_BITS_DEF;
   localparam int VAL_W       = cslx_pkg::VALUE_BITS_DEF;
   localparam int FRAC_W      = cslx_pkg::FRAC_BITS_DEF;
   localparam int DATA_W      = ((LINE_W + VAL_W + FRAC_W + LEN_W + 7) / 8) * 8;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 8;
   localparam int PHASE_ITEMS = 330;
   localparam logic [WEIGHT_W-1:0] TENTH_Q32 = 32'h1999999A;

   typedef enum logic [cslx_pkg::MODE_W-1:0] {
      SM_IDLE, SM_SLASH, SM_LINE_CMT, SM_BLOCK_CMT, SM_BLOCK_STAR,
      SM_INT, SM_FRAC, SM_WORD, SM_REL
   } scan_mode_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [LINE_W-1:0] line;
      logic [VAL_W-1:0]  ival;
      logic [FRAC_W-1:0] fval;
      logic [LEN_W-1:0]  len;
      logic              last;
   } lex_token_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              is_end;
   } char_word_type;

   // a typed row carries the one token it must produce
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              is_end;
      logic              typed;
      lex_token_type     tok;
   } dir_row_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [CHAR_W-1:0] req_tdata  = '0;   // ch
   logic              req_tuser  = 1'b0; // is_end
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;         // line_no, int_value, frac_value, ident_len
   logic [TAG_W-1:0]  rsp_tuser;         // tag
   logic              rsp_tlast;

   // scanner model state
   scan_mode_type       scan_mode;
   logic [CHAR_W-1:0]   rel_first;
   logic [LINE_W-1:0]   cur_line;
   logic [VAL_W-1:0]    num_int;
   logic [FRAC_W-1:0]   num_frac;
   logic [WEIGHT_W-1:0] frac_step;
   logic [LEN_W-1:0]    word_len;

   lex_token_type step_tokens[$];
   lex_token_type pending_tokens[$];
   char_word_type char_plan[$];
   dir_row_type   dir_table[$];

   int err_count      = 0;
   int chars_sent     = 0;
   int tokens_checked = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_req       = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   char_stream_lexer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic bit is_digit_ch(input logic [CHAR_W-1:0] c);
      return c >= cslx_pkg::CH_ZERO && c <= cslx_pkg::CH_NINE;
   endfunction

   function automatic bit is_letter_ch(input logic [CHAR_W-1:0] c);
      return (c >= cslx_pkg::CH_UC_A && c <= cslx_pkg::CH_UC_Z) ||
             (c >= cslx_pkg::CH_LC_A && c <= cslx_pkg::CH_LC_Z);
   endfunction

   function automatic logic [CHAR_W-1:0] rand_byte();
      return CHAR_W'($urandom_range(255));
   endfunction

   task automatic emit(input logic [TAG_W-1:0] tag, input logic [VAL_W-1:0] iv,
                       input logic [FRAC_W-1:0] fv, input logic [LEN_W-1:0] len);
      lex_token_type t;
      if (step_tokens.size() < 2) begin
         t.tag  = tag;
         t.line = cur_line;
         t.ival = iv;
         t.fval = fv;
         t.len  = len;
         t.last = 1'b0;
         step_tokens.push_back(t);
      end
   endtask

   task automatic drop_token_state();
      num_int   = '0;
      num_frac  = '0;
      frac_step = TENTH_Q32;
      word_len  = '0;
      rel_first = '0;
   endtask

   task automatic reset_scanner();
      scan_mode = SM_IDLE;
      cur_line  = LINE_W'(1);
      drop_token_state();
   endtask

   task automatic bump_line();
      if (cur_line != '1) cur_line = cur_line + 1'b1;
   endtask

   task automatic close_token();
      case (scan_mode)
         SM_SLASH: emit({1'b0, cslx_pkg::CH_SLASH}, '0, '0, '0);
         SM_INT, SM_FRAC: emit(cslx_pkg::TAG_NUM, num_int, num_frac, '0);
         SM_WORD: emit(cslx_pkg::TAG_ID, '0, '0, word_len);
         SM_REL: begin
            if (rel_first == cslx_pkg::CH_LT) emit(cslx_pkg::TAG_LT, '0, '0, '0);
            else if (rel_first == cslx_pkg::CH_GT) emit(cslx_pkg::TAG_GT, '0, '0, '0);
            else emit({1'b0, rel_first}, '0, '0, '0);
         end
         default: ;
      endcase
      scan_mode = SM_IDLE;
      drop_token_state();
   endtask

   task automatic begin_token(input logic [CHAR_W-1:0] c);
      scan_mode = SM_IDLE;
      if (c == cslx_pkg::CH_SPACE || c == cslx_pkg::CH_TAB) begin
      end else if (c == cslx_pkg::CH_NL) begin
         bump_line();
      end else if (c == cslx_pkg::CH_SLASH) begin
         scan_mode = SM_SLASH;
      end else if (is_digit_ch(c)) begin
         num_int   = VAL_W'(c - cslx_pkg::CH_ZERO);
         scan_mode = SM_INT;
      end else if (c == cslx_pkg::CH_DOT) begin
         num_int   = '0;
         scan_mode = SM_FRAC;
      end else if (is_letter_ch(c)) begin
         word_len  = LEN_W'(1);
         scan_mode = SM_WORD;
      end else if (c == cslx_pkg::CH_LT || c == cslx_pkg::CH_GT ||
                   c == cslx_pkg::CH_EQ || c == cslx_pkg::CH_BANG) begin
         rel_first = c;
         scan_mode = SM_REL;
      end else begin
         emit({1'b0, c}, '0, '0, '0);
      end
   endtask

   task automatic accum_int(input int unsigned d);
      longint unsigned top;
      top = (longint'(1) << VAL_W) - 1;
      if (longint'(num_int) > (top - d) / 10) num_int = '1;
      else num_int = VAL_W'(longint'(num_int) * 10 + d);
   endtask

   task automatic accum_frac(input int unsigned d);
      longint unsigned prod;
      longint unsigned top;
      top  = (longint'(1) << FRAC_W) - 1;
      prod = longint'(d) * longint'(frac_step);
      // round half up from Q0.32 to the fraction width
      prod = (prod + (longint'(1) << (WEIGHT_W - FRAC_W - 1))) >> (WEIGHT_W - FRAC_W);
      if (prod > top - longint'(num_frac)) num_frac = '1;
      else num_frac = FRAC_W'(longint'(num_frac) + prod);
      frac_step = WEIGHT_W'((longint'(frac_step) + 5) / 10);
   endtask

   // one character or end mark in, its tokens into step_tokens
   task automatic scan_char(input logic [CHAR_W-1:0] c, input logic e);
      lex_token_type t;
      step_tokens.delete();
      if (e) begin
         close_token();
         emit(cslx_pkg::TAG_END, '0, '0, '0);
         reset_scanner();
      end else begin
         case (scan_mode)
            SM_SLASH: begin
               if (c == cslx_pkg::CH_SLASH) scan_mode = SM_LINE_CMT;
               else if (c == cslx_pkg::CH_STAR) scan_mode = SM_BLOCK_CMT;
               else begin
                  close_token();
                  begin_token(c);
               end
            end
            SM_LINE_CMT: begin
               if (c == cslx_pkg::CH_NL) begin
                  bump_line();
                  scan_mode = SM_IDLE;
               end
            end
            SM_BLOCK_CMT: begin
               if (c == cslx_pkg::CH_STAR) scan_mode = SM_BLOCK_STAR;
               else if (c == cslx_pkg::CH_NL) bump_line();
            end
            SM_BLOCK_STAR: begin
               if (c == cslx_pkg::CH_SLASH) scan_mode = SM_IDLE;
               else if (c != cslx_pkg::CH_STAR) begin
                  if (c == cslx_pkg::CH_NL) bump_line();
                  scan_mode = SM_BLOCK_CMT;
               end
            end
            SM_INT: begin
               if (is_digit_ch(c)) accum_int(32'(c - cslx_pkg::CH_ZERO));
               else if (c == cslx_pkg::CH_DOT) scan_mode = SM_FRAC;
               else begin
                  close_token();
                  begin_token(c);
               end
            end
            SM_FRAC: begin
               if (is_digit_ch(c)) accum_frac(32'(c - cslx_pkg::CH_ZERO));
               else begin
                  close_token();
                  begin_token(c);
               end
            end
            SM_WORD: begin
               if (is_letter_ch(c)) begin
                  if (word_len != '1) word_len = word_len + 1'b1;
               end else begin
                  close_token();
                  begin_token(c);
               end
            end
            SM_REL: begin
               if (c == cslx_pkg::CH_EQ) begin
                  if (rel_first == cslx_pkg::CH_LT) emit(cslx_pkg::TAG_LE, '0, '0, '0);
                  else if (rel_first == cslx_pkg::CH_GT) emit(cslx_pkg::TAG_GE, '0, '0, '0);
                  else if (rel_first == cslx_pkg::CH_EQ) emit(cslx_pkg::TAG_EQ, '0, '0, '0);
                  else emit(cslx_pkg::TAG_NE, '0, '0, '0);
                  scan_mode = SM_IDLE;
                  drop_token_state();
               end else begin
                  close_token();
                  begin_token(c);
               end
            end
            default: begin_token(c);
         endcase
      end
      if (step_tokens.size() > 0) begin
         t = step_tokens.pop_back();
         t.last = 1'b1;
         step_tokens.push_back(t);
      end
   endtask

   // ---------------------------------------------------------------- sender

   task automatic drive_char(input logic [CHAR_W-1:0] c, input logic e,
                             input logic use_typed, input lex_token_type typed_tok);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= e;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
      scan_char(c, e);
      if (use_typed) pending_tokens.push_back(typed_tok);
      else foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
   endtask

   task automatic plan(input logic [CHAR_W-1:0] c, input logic e);
      char_word_type w;
      w.ch     = c;
      w.is_end = e;
      char_plan.push_back(w);
   endtask

   task automatic plan_digits(input int n);
      bit nines;
      logic [CHAR_W-1:0] c;
      nines = ($urandom_range(7) == 0);
      repeat (n) begin
         c = CHAR_W'(cslx_pkg::CH_ZERO + $urandom_range(9));
         plan(nines ? cslx_pkg::CH_NINE : c, 1'b0);
      end
   endtask

   task automatic plan_letter();
      logic [CHAR_W-1:0] base;
      base = $urandom_range(1) ? cslx_pkg::CH_UC_A : cslx_pkg::CH_LC_A;
      plan(CHAR_W'(base + $urandom_range(25)), 1'b0);
   endtask

   // one piece of token text, mostly well formed
   task automatic plan_fragment();
      int pick;
      logic [CHAR_W-1:0] c;
      pick = $urandom_range(99);
      if (pick < 22) begin
         if ($urandom_range(9) == 0) plan(cslx_pkg::CH_DOT, 1'b0);
         else plan_digits($urandom_range(12, 1));
         if ($urandom_range(1)) begin
            plan(cslx_pkg::CH_DOT, 1'b0);
            plan_digits($urandom_range(12));
         end
      end else if (pick < 40) begin
         repeat ($urandom_range(10, 1)) plan_letter();
      end else if (pick < 52) begin
         case ($urandom_range(3))
            0: plan(cslx_pkg::CH_LT, 1'b0);
            1: plan(cslx_pkg::CH_GT, 1'b0);
            2: plan(cslx_pkg::CH_EQ, 1'b0);
            default: plan(cslx_pkg::CH_BANG, 1'b0);
         endcase
         if ($urandom_range(1)) plan(cslx_pkg::CH_EQ, 1'b0);
      end else if (pick < 64) begin
         case ($urandom_range(2))
            0: plan(cslx_pkg::CH_SPACE, 1'b0);
            1: plan(cslx_pkg::CH_TAB, 1'b0);
            default: plan(cslx_pkg::CH_NL, 1'b0);
         endcase
      end else if (pick < 69) begin
         plan(cslx_pkg::CH_SLASH, 1'b0);
         plan(cslx_pkg::CH_SLASH, 1'b0);
         repeat ($urandom_range(8)) begin
            c = rand_byte();
            plan(c == cslx_pkg::CH_NL ? cslx_pkg::CH_SPACE : c, 1'b0);
         end
         plan(cslx_pkg::CH_NL, 1'b0);
      end else if (pick < 75) begin
         plan(cslx_pkg::CH_SLASH, 1'b0);
         plan(cslx_pkg::CH_STAR, 1'b0);
         repeat ($urandom_range(8)) begin
            case ($urandom_range(4))
               0: plan(cslx_pkg::CH_STAR, 1'b0);
               1: plan(cslx_pkg::CH_NL, 1'b0);
               2: plan(cslx_pkg::CH_SLASH, 1'b0);
               default: plan(rand_byte(), 1'b0);
            endcase
         end
         // sometimes left open and cut off by an end mark
         if ($urandom_range(7) == 0) plan(rand_byte(), 1'b1);
         else begin
            repeat ($urandom_range(3, 1)) plan(cslx_pkg::CH_STAR, 1'b0);
            plan(cslx_pkg::CH_SLASH, 1'b0);
         end
      end else if (pick < 79) begin
         plan(cslx_pkg::CH_SLASH, 1'b0);
      end else if (pick < 95) begin
         plan(rand_byte(), 1'b0);
      end else begin
         plan(rand_byte(), 1'b1);
      end
   endtask

   task automatic drain_and_settle();
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic run_plan();
      lex_token_type none;
      none = '0;
      while (char_plan.size() != 0) begin
         char_word_type w;
         w = char_plan.pop_front();
         drive_char(w.ch, w.is_end, 1'b0, none);
      end
      req_tvalid <= 1'b0;
   endtask

   function automatic dir_row_type dir_row(input logic [CHAR_W-1:0] c, input logic e,
                                           input logic typed, input logic [TAG_W-1:0] tag,
                                           input int line, input int len);
      dir_row_type r;
      r.ch       = c;
      r.is_end   = e;
      r.typed    = typed;
      r.tok.tag  = tag;
      r.tok.line = LINE_W'(line);
      r.tok.ival = '0;
      r.tok.fval = '0;
      r.tok.len  = LEN_W'(len);
      r.tok.last = 1'b1;
      return r;
   endfunction

   initial begin
      reset_scanner();
      // extremes of the byte, the operators and each odd corner of the scanner
      dir_table.push_back(dir_row(8'd0,   1'b0, 1'b1, 9'd0,   1, 0));
      dir_table.push_back(dir_row(8'd255, 1'b0, 1'b1, 9'd255, 1, 0));
      dir_table.push_back(dir_row(cslx_pkg::CH_LT,   1'b0, 1'b0, '0, 0, 0));
      dir_table.push_back(dir_row(cslx_pkg::CH_EQ,   1'b0, 1'b1, cslx_pkg::TAG_LE, 1, 0));
      dir_table.push_back(dir_row(cslx_pkg::CH_BANG, 1'b0, 1'b0, '0, 0, 0));
      // lone bang kept as its own token
      dir_table.push_back(dir_row("a", 1'b0, 1'b1, {1'b0, cslx_pkg::CH_BANG}, 1, 0));
      dir_table.push_back(dir_row(cslx_pkg::CH_GT,   1'b0, 1'b1, cslx_pkg::TAG_ID, 1, 1));
      // greater-than without equals, the dot starts a number
      dir_table.push_back(dir_row(cslx_pkg::CH_DOT,  1'b0, 1'b1, cslx_pkg::TAG_GT, 1, 0));
      dir_table.push_back(dir_row("5",               1'b0, 1'b0, '0, 0, 0));
      dir_table.push_back(dir_row(cslx_pkg::CH_DOT,  1'b0, 1'b0, '0, 0, 0));
      // lone dot is the number zero
      dir_table.push_back(dir_row(cslx_pkg::CH_NL,   1'b0, 1'b1, cslx_pkg::TAG_NUM, 1, 0));
      // star run closing a block comment
      dir_table.push_back(dir_row(cslx_pkg::CH_SLASH, 1'b0, 1'b0, '0, 0, 0));
      dir_table.push_back(dir_row(cslx_pkg::CH_STAR,  1'b0, 1'b0, '0, 0, 0));
      dir_table.push_back(dir_row(cslx_pkg::CH_STAR,  1'b0, 1'b0, '0, 0, 0));
      dir_table.push_back(dir_row(cslx_pkg::CH_STAR,  1'b0, 1'b0, '0, 0, 0));
      dir_table.push_back(dir_row(cslx_pkg::CH_SLASH, 1'b0, 1'b0, '0, 0, 0));
      // lone slash, then equals-equals
      dir_table.push_back(dir_row(cslx_pkg::CH_SLASH, 1'b0, 1'b0, '0, 0, 0));
      dir_table.push_back(dir_row(cslx_pkg::CH_EQ,    1'b0, 1'b0, '0, 0, 0));
      dir_table.push_back(dir_row(cslx_pkg::CH_EQ,    1'b0, 1'b1, cslx_pkg::TAG_EQ, 2, 0));
      // open comment dropped at the end mark
      dir_table.push_back(dir_row(cslx_pkg::CH_SLASH, 1'b0, 1'b0, '0, 0, 0));
      dir_table.push_back(dir_row(cslx_pkg::CH_STAR,  1'b0, 1'b0, '0, 0, 0));
      dir_table.push_back(dir_row("z",                1'b0, 1'b0, '0, 0, 0));
      dir_table.push_back(dir_row(8'hA5,              1'b1, 1'b1, cslx_pkg::TAG_END, 2, 0));
      // lone equals flushed by the end mark, line count back to one
      dir_table.push_back(dir_row(cslx_pkg::CH_EQ,    1'b0, 1'b0, '0, 0, 0));
      dir_table.push_back(dir_row(8'h5A,              1'b1, 1'b0, '0, 0, 0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i])
         drive_char(dir_table[i].ch, dir_table[i].is_end, dir_table[i].typed,
                    dir_table[i].tok);
      req_tvalid <= 1'b0;
      drain_and_settle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 52; end
            default: begin send_idle_pct = 27; recv_stall_pct <= 27; end
         endcase
         // long receiver hold-off while the sender keeps pushing
         if (phase == 0) hold_req <= hold_req + 1;
         while (char_plan.size() < PHASE_ITEMS) plan_fragment();
         plan(rand_byte(), 1'b1);
         run_plan();
         drain_and_settle();
      end

      if (pending_tokens.size() != 0)
         $error("%0d tokens never arrived", pending_tokens.size());
      $display("run covered %0d characters and end marks: directed table and four",
               chars_sent);
      $display("random idle/stall phases with one long receiver hold; %0d tokens compared",
               tokens_checked);
      if (err_count == 0 && pending_tokens.size() == 0)
         $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   task automatic check_field(input string name, input longint unsigned exp_v,
                              input longint unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      lex_token_type exp_tok;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_tokens.size() == 0) begin
               $error("token with tag %0d arrived with nothing expected", rsp_tuser);
               err_count++;
            end else begin
               exp_tok = pending_tokens.pop_front();
               tokens_checked++;
               check_field("tag", 64'(exp_tok.tag), 64'(rsp_tuser));
               check_field("line_no", 64'(exp_tok.line), 64'(rsp_tdata[LINE_W-1:0]));
               check_field("int_value", 64'(exp_tok.ival),
                           64'(rsp_tdata[LINE_W +: VAL_W]));
               check_field("frac_value", 64'(exp_tok.fval),
                           64'(rsp_tdata[LINE_W+VAL_W +: FRAC_W]));
               check_field("ident_len", 64'(exp_tok.len),
                           64'(rsp_tdata[LINE_W+VAL_W+FRAC_W +: LEN_W]));
               check_field("last", 64'(exp_tok.last), 64'(rsp_tlast));
            end
         end
         if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no word moved on either channel for %0d cycles", QUIET_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

### files.f
src/cslx_pkg.sv
src/cslx_front.sv
src/cslx_back.sv
src/cslx_rspq.sv
src/char_stream_lexer_unit.sv
src/cslx_checker.sv
sim/char_stream_lexer_unit_tb.sv
